// File: hw/rtl/rldr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rldr_pkg
// Shared types and constants of the run-length decode and reverse unit.
// ---------------------------------------------------------------------------
package rldr_pkg;

    // Character codes used by the symbol classifier.
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_Z = 8'h7A;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INPUT = 2'd1,
        ST_IN_LONG   = 2'd2,
        ST_OUT_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic take;    // input transfer in this cycle
        logic expand;  // one buffer write step of a letter
        logic rd_en;   // read the buffer at the read pointer
        logic pop;     // output transfer in this cycle
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_eol;        // the offered item closes the line
        logic start_expand;  // the offered symbol is a letter to be buffered
        logic has_chars;     // the offered end of line reports letters
        logic expand_done;   // the current write step is the final one
        logic last;          // the held result is the final one of the line
    } t_sts;

endpackage
`default_nettype wire

// File: hw/rtl/run_length_decode_reverse_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// run_length_decode_reverse_unit
// Run-length decoder that reports each line with its letters last-first.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one symbol or
//   an end-of-line mark per transfer. Letters a-z are buffered once, a digit
//   1-9 repeats the following letter. Symbols cause no result.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries the
//   report of a line: if it has letters and no error, those letters in reverse
//   order, else one result with char_valid low and the line status; last marks the end.
// Timing:
//   A digit or a rejected symbol is simply taken; a letter repeated n times is
//   taken, then written in n steps, one buffer write per cycle. After an end of
//   line each letter passes a registered buffer read (S_READ), then the output
//   register (S_EMIT), so the first result is shown only after S_READ.
//   An error or empty report is shown in the cycle after the mark.
//   No input is taken while a line is being reported; a stalled receiver
//   simply holds the current result in the output register.
// Reset:
//   Synchronous, active low; clears all counters and errors. The letter
//   buffer is not cleared, as only entries written in the line are read.
// ---------------------------------------------------------------------------
module run_length_decode_reverse_unit #(
    parameter int IN_MAX  = 32,
    parameter int OUT_MAX = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  rldr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rldr_pkg::t_out_item o_out_item
);
    import rldr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rldr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rldr_dpath #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire

// File: hw/rtl/rldr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rldr_ctrl
// Sequencer: takes symbols, runs letter expansion, then reports the line.
// ---------------------------------------------------------------------------
module rldr_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  rldr_pkg::t_sts  i_sts,
    output rldr_pkg::t_cmd  o_cmd
);
    import rldr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_READ   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid) begin
                    if (i_sts.is_eol) begin
                        n_state = i_sts.has_chars ? S_READ : S_EMIT;
                    end else if (i_sts.start_expand) begin
                        n_state = S_EXPAND;
                    end
                end
            end
            S_EXPAND: begin
                o_cmd.expand = 1'b1;
                if (i_sts.expand_done) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.pop   = i_out_ready;
                if (i_out_ready) begin
                    n_state = i_sts.last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rldr_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rldr_dpath
// Symbol checks, line counters, letter buffer and the result register.
// ---------------------------------------------------------------------------
module rldr_dpath #(
    parameter int IN_MAX  = 32,
    parameter int OUT_MAX = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rldr_pkg::t_in_item  i_in_item,
    input  rldr_pkg::t_cmd      i_cmd,
    output rldr_pkg::t_sts      o_sts,
    output rldr_pkg::t_out_item o_out_item
);
    import rldr_pkg::*;

    localparam int ICW = $clog2(IN_MAX + 1);
    localparam int OCW = $clog2(OUT_MAX + 1);
    localparam int AW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam logic [ICW-1:0] IN_LIMIT  = ICW'(IN_MAX);
    localparam logic [OCW-1:0] OUT_LIMIT = OCW'(OUT_MAX);

    logic [7:0]     r_mem [OUT_MAX];
    logic [ICW-1:0] r_in_count, n_in_count;
    logic [OCW-1:0] r_out_count, n_out_count;
    logic [3:0]     r_pending, n_pending;
    t_status        r_read_err, n_read_err;
    t_status        r_expand_err, n_expand_err;
    logic [3:0]     r_rep, n_rep;
    logic [7:0]     r_letter;
    t_status        r_status, n_status;
    logic           r_chars, n_chars;
    logic [AW-1:0]  r_rd_idx, n_rd_idx;
    logic [7:0]     r_rd_data;

    logic           is_letter;
    logic           is_digit;
    logic           in_full;
    logic           wr_en;
    t_status        read_fin;
    t_status        expand_fin;
    t_status        line_status;

    assign is_letter = (i_in_item.symbol >= CH_A) && (i_in_item.symbol <= CH_Z);
    assign is_digit  = (i_in_item.symbol >= CH_1) && (i_in_item.symbol <= CH_9);
    assign in_full   = (r_in_count >= IN_LIMIT);

    // Status at end of line: read errors win, then expansion errors.
    assign read_fin    = (r_read_err != ST_OK) ? r_read_err
                       : (in_full ? ST_IN_LONG : ST_OK);
    assign expand_fin  = (r_expand_err != ST_OK) ? r_expand_err
                       : ((r_pending != 4'd0) ? ST_BAD_INPUT : ST_OK);
    assign line_status = (read_fin != ST_OK) ? read_fin : expand_fin;

    assign wr_en = i_cmd.expand && (r_expand_err == ST_OK) && (r_out_count < OUT_LIMIT);

    always_comb begin
        o_sts.is_eol       = i_in_item.end_of_line;
        o_sts.start_expand = !i_in_item.end_of_line && (r_read_err == ST_OK) && !in_full
                           && is_letter && (r_expand_err == ST_OK);
        o_sts.has_chars    = (line_status == ST_OK) && (r_out_count != '0);
        o_sts.expand_done  = (r_rep == 4'd1);
        o_sts.last         = !r_chars || (r_rd_idx == '0);
    end

    always_comb begin
        n_in_count   = r_in_count;
        n_out_count  = r_out_count;
        n_pending    = r_pending;
        n_read_err   = r_read_err;
        n_expand_err = r_expand_err;
        n_rep        = r_rep;
        n_status     = r_status;
        n_chars      = r_chars;
        n_rd_idx     = r_rd_idx;
        if (i_cmd.take && i_in_item.end_of_line) begin
            // Latch the report and clear the line; the buffer keeps its letters.
            n_status     = line_status;
            n_chars      = o_sts.has_chars;
            n_rd_idx     = AW'(r_out_count - OCW'(1));
            n_in_count   = '0;
            n_out_count  = '0;
            n_pending    = 4'd0;
            n_read_err   = ST_OK;
            n_expand_err = ST_OK;
        end else if (i_cmd.take && (r_read_err == ST_OK)) begin
            if (in_full) begin
                n_read_err = ST_IN_LONG;
            end else if (!is_letter && !is_digit) begin
                n_read_err = ST_BAD_INPUT;
            end else begin
                n_in_count = r_in_count + ICW'(1);
                if (r_expand_err == ST_OK) begin
                    if (is_digit) begin
                        if (r_pending != 4'd0) begin
                            n_expand_err = ST_BAD_INPUT;
                        end else begin
                            n_pending = i_in_item.symbol[3:0];
                        end
                    end else begin
                        n_rep     = (r_pending != 4'd0) ? r_pending : 4'd1;
                        n_pending = 4'd0;
                    end
                end
            end
        end
        if (i_cmd.expand) begin
            n_rep = r_rep - 4'd1;
            if (wr_en) begin
                n_out_count = r_out_count + OCW'(1);
            end else if (r_expand_err == ST_OK) begin
                n_expand_err = ST_OUT_LONG;
            end
        end
        if (i_cmd.pop && r_chars && (r_rd_idx != '0)) begin
            n_rd_idx = r_rd_idx - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count   <= '0;
            r_out_count  <= '0;
            r_pending    <= 4'd0;
            r_read_err   <= ST_OK;
            r_expand_err <= ST_OK;
            r_rep        <= 4'd0;
            r_status     <= ST_OK;
            r_chars      <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            r_in_count   <= n_in_count;
            r_out_count  <= n_out_count;
            r_pending    <= n_pending;
            r_read_err   <= n_read_err;
            r_expand_err <= n_expand_err;
            r_rep        <= n_rep;
            r_status     <= n_status;
            r_chars      <= n_chars;
            r_rd_idx     <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_sts.start_expand) begin
            r_letter <= i_in_item.symbol;
        end
    end

    // Letter buffer: one write port for expansion, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_out_count[AW-1:0]] <= r_letter;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_comb begin
        o_out_item.out_char   = r_chars ? r_rd_data : 8'd0;
        o_out_item.char_valid = r_chars;
        o_out_item.status     = r_status;
        o_out_item.last       = o_sts.last;
    end

endmodule
`default_nettype wire
